// ----- design/scale2x_pixel_upscaler_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Scale2x upscaler assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SCALE2X_PIXEL_UPSCALER_UNIT_DEFINES_SVH
`define SCALE2X_PIXEL_UPSCALER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock outside of reset.
`define SX2_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside of reset.
`define SX2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sx2_pkg.sv -----
// ----------------------------------------------------------------------------
// sx2_pkg
// Types, constants and the Scale2x rule shared by the upscaler modules.
// ----------------------------------------------------------------------------
package sx2_pkg;

  localparam int PIX_W  = 32;
  localparam int MAX_W  = 1024;
  localparam int COL_W  = $clog2(MAX_W);
  localparam int MAX_H  = 4096;
  localparam int ROW_W  = $clog2(MAX_H);
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int CFG_W  = 13;
  localparam int BANK_N = 3;
  localparam int BANK_W = 2;
  localparam int QDEPTH = 2;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [BANK_W-1:0] bank_sel_t;

  // One classified source pixel with the line store words it needs.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             row_end;
    logic             last_row;
    logic [PIX_W-1:0] r1_next;
    logic [PIX_W-1:0] r2_cur;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] br;
  } blk_t;

  // P centre, A above, B right, C left, D below.
  function automatic blk_t sx2_rule(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] a,
                                    input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c,
                                    input logic [PIX_W-1:0] d);
    blk_t r;
    r.tl = (c == a && c != d && a != b) ? a : p;
    r.tr = (a == b && a != c && b != d) ? b : p;
    r.bl = (d == c && d != b && c != a) ? c : p;
    r.br = (b == d && b != a && d != c) ? d : p;
    return r;
  endfunction

endpackage

// ----- design/scale2x_pixel_upscaler_unit.sv -----
// ----------------------------------------------------------------------------
// scale2x_pixel_upscaler_unit
// Streaming Scale2x 2x upscaler: raster pixels in, 2x2 output blocks out.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_valid/in_ready   | pixel
//  out_    | output    | out_valid/out_ready | 2x2 block, source column/row, flags
//  cfg_    | input     | cfg_wr_en           | register index and write data
//
// One pixel is taken per clock unless the queue is full; the block engine emits
// one block per clock while the output is free. Inner rows give one block per
// pixel; in the last row each pixel past column 0 also gives the block to its
// left, and the final pixel its own too. The first row of a taller frame gives
// no blocks. Reset is synchronous; line stores, not cleared, need one full row
// written before they are read. The queue buffers stalls on either side.
// ----------------------------------------------------------------------------
`include "scale2x_pixel_upscaler_unit_defines.svh"

module scale2x_pixel_upscaler_unit
  import sx2_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_top_left,
  output logic [PIX_W-1:0] out_top_right,
  output logic [PIX_W-1:0] out_bottom_left,
  output logic [PIX_W-1:0] out_bottom_right,
  output logic [COL_W-1:0] out_src_col,
  output logic [ROW_W-1:0] out_src_row,
  output logic             out_run_last,
  output logic             out_frame_last
);

  logic  f_valid, f_ready;
  item_t f_item;
  logic  q_valid, q_pop;
  item_t q_item;

  sx2_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_item    (f_item)
  );

  sx2_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_item   (q_item)
  );

  sx2_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_item           (q_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_top_left     (out_top_left),
    .out_top_right    (out_top_right),
    .out_bottom_left  (out_bottom_left),
    .out_bottom_right (out_bottom_right),
    .out_src_col      (out_src_col),
    .out_src_row      (out_src_row),
    .out_run_last     (out_run_last),
    .out_frame_last   (out_frame_last)
  );

  `SX2_ASSERT_IMPL(a_frame_last_ends_run, out_valid && out_frame_last, out_run_last, "frame end block is not the last block of its pixel")
  `SX2_ASSERT_IMPL(a_pop_needs_entry, q_pop, q_valid, "engine retired a request from an empty queue")
  `SX2_ASSERT_NEXT(a_head_kept, q_valid && !q_pop, q_valid, "queued request vanished without being retired")

endmodule

// ----- design/sx2_fifo.sv -----
// ----------------------------------------------------------------------------
// sx2_fifo
// Short request queue between the classifying front and the block engine.
// ----------------------------------------------------------------------------
module sx2_fifo
  import sx2_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t            entry_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign pop_valid  = (cnt_r != '0);
  assign do_pop     = pop_valid && pop_ready;
  assign push_ready = (cnt_r != CNT_W'(QDEPTH)) || do_pop;
  assign do_push    = push_valid && push_ready;
  assign pop_item   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- design/sx2_front.sv -----
// ----------------------------------------------------------------------------
// sx2_front
// Accepts source pixels, tracks the raster position, owns the three rotating
// line stores and hands classified requests to the queue.
// ----------------------------------------------------------------------------
module sx2_front
  import sx2_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel,
  output logic             q_valid,
  input  logic             q_ready,
  output item_t            q_item
);

  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  bank_sel_t        now_r, now_nxt;
  bank_sel_t        one_sel, two_sel;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;
  logic             row_end, last_row, accept;

  logic [PIX_W-1:0] line_mem [BANK_N][MAX_W];
  logic [PIX_W-1:0] rd_q_r   [BANK_N];
  logic [COL_W-1:0] rd_addr  [BANK_N];

  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pixel_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_row_end_r, s1_last_row_r;
  bank_sel_t        s1_one_r, s1_two_r;

  function automatic bank_sel_t bank_inc(input bank_sel_t b);
    return (b == BANK_W'(BANK_N - 1)) ? '0 : b + 1'b1;
  endfunction

  function automatic bank_sel_t bank_dec(input bank_sel_t b);
    return (b == '0) ? BANK_W'(BANK_N - 1) : b - 1'b1;
  endfunction

  // Roles rotate at each row end: the oldest store becomes the one being filled.
  assign one_sel = bank_dec(now_r);
  assign two_sel = bank_inc(now_r);

  always_comb begin
    if (width_r == '0) begin
      col_last = '0;
    end else if (width_r > WID_W'(MAX_W)) begin
      col_last = COL_W'(MAX_W - 1);
    end else begin
      col_last = COL_W'(width_r - 1'b1);
    end
    if (height_r == '0) begin
      row_last = '0;
    end else if (height_r > HGT_W'(MAX_H)) begin
      row_last = ROW_W'(MAX_H - 1);
    end else begin
      row_last = ROW_W'(height_r - 1'b1);
    end
  end

  assign row_end  = (col_r >= col_last);
  assign last_row = (row_r >= row_last);
  assign in_ready = !s1_valid_r || q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    now_nxt = now_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
        now_nxt = bank_inc(now_r);
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    s1_valid_nxt = accept ? 1'b1 : (q_ready ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WID_W'(64);
      height_r   <= HGT_W'(64);
      col_r      <= '0;
      row_r      <= '0;
      now_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_WIDTH:  width_r  <= cfg_wdata[WID_W-1:0];
          CFG_HEIGHT: height_r <= cfg_wdata[HGT_W-1:0];
          default:    ;
        endcase
      end
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      now_r      <= now_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // The row above is read one column ahead so the engine can slide a window.
  always_comb begin
    for (int g = 0; g < BANK_N; g++) begin
      rd_addr[g] = (BANK_W'(g) == one_sel) ? col_r + 1'b1 : col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int g = 0; g < BANK_N; g++) begin
        if (BANK_W'(g) == now_r) begin
          line_mem[g][col_r] <= in_pixel;
        end
        rd_q_r[g] <= line_mem[g][rd_addr[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel_r    <= in_pixel;
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
      s1_row_end_r  <= row_end;
      s1_last_row_r <= last_row;
      s1_one_r      <= one_sel;
      s1_two_r      <= two_sel;
    end
  end

  assign q_valid          = s1_valid_r;
  assign q_item.pixel     = s1_pixel_r;
  assign q_item.col       = s1_col_r;
  assign q_item.row       = s1_row_r;
  assign q_item.row_end   = s1_row_end_r;
  assign q_item.last_row  = s1_last_row_r;
  assign q_item.r1_next   = rd_q_r[s1_one_r];
  assign q_item.r2_cur    = rd_q_r[s1_two_r];

endmodule

// ----- design/sx2_back.sv -----
// ----------------------------------------------------------------------------
// sx2_back
// Block engine: keeps a sliding window of the row above plus the recent pixels
// of the current row; emits one 2x2 block per cycle while the output is free.
// ----------------------------------------------------------------------------
module sx2_back
  import sx2_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_pop,
  input  item_t            q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_top_left,
  output logic [PIX_W-1:0] out_top_right,
  output logic [PIX_W-1:0] out_bottom_left,
  output logic [PIX_W-1:0] out_bottom_right,
  output logic [COL_W-1:0] out_src_col,
  output logic [ROW_W-1:0] out_src_row,
  output logic             out_run_last,
  output logic             out_frame_last
);

  // Blocks a single request can cause, in emission order.
  localparam int BLK_ABOVE = 0;
  localparam int BLK_LEFT  = 1;
  localparam int BLK_SELF  = 2;
  localparam int BLK_N     = 3;

  logic [PIX_W-1:0] w_prev_r, w_cur_r, r1_first_r, first_now_r, h1_r, h2_r;
  logic [BLK_N-1:0] done_r, done_nxt;
  logic             out_valid_r, out_valid_nxt;
  blk_t             blk_r;
  logic [COL_W-1:0] col_out_r;
  logic [ROW_W-1:0] row_out_r;
  logic             run_last_r, frame_last_r;

  logic [BLK_N-1:0] need, rem, pick;
  logic [PIX_W-1:0] cur, p, a, b, c, d;
  logic [COL_W-1:0] col_sel;
  logic [ROW_W-1:0] row_sel;
  logic             col_zero, is_last, out_free, emit, retire;
  blk_t             blk;

  assign col_zero = (q_item.col == '0);
  assign cur      = col_zero ? r1_first_r : w_cur_r;

  always_comb begin
    need[BLK_ABOVE] = (q_item.row != '0);
    need[BLK_LEFT]  = q_item.last_row && !col_zero;
    need[BLK_SELF]  = q_item.last_row && q_item.row_end;
    rem  = need & ~done_r;
    pick = rem & (~rem + 1'b1);
    is_last = ((rem & ~pick) == '0);
  end

  assign out_free = !out_valid_r || out_ready;
  assign emit     = q_valid && (rem != '0) && out_free;
  assign retire   = q_valid && ((rem == '0) || (emit && is_last));
  assign q_pop    = retire;

  // Neighbours outside the frame fall back to the centre pixel.
  always_comb begin
    p = q_item.pixel;
    a = q_item.pixel;
    b = q_item.pixel;
    c = h1_r;
    d = q_item.pixel;
    col_sel = q_item.col;
    row_sel = q_item.row;
    if (pick[BLK_ABOVE]) begin
      p = cur;
      a = (q_item.row > ROW_W'(1)) ? q_item.r2_cur : cur;
      b = q_item.row_end ? cur : q_item.r1_next;
      c = col_zero ? cur : w_prev_r;
      d = q_item.pixel;
      row_sel = q_item.row - 1'b1;
    end else if (pick[BLK_LEFT]) begin
      p = h1_r;
      a = (q_item.row != '0) ? w_prev_r : h1_r;
      b = q_item.pixel;
      c = (q_item.col > COL_W'(1)) ? h2_r : h1_r;
      d = h1_r;
      col_sel = q_item.col - 1'b1;
    end else begin
      p = q_item.pixel;
      a = (q_item.row != '0) ? cur : q_item.pixel;
      b = q_item.pixel;
      c = col_zero ? q_item.pixel : h1_r;
      d = q_item.pixel;
    end
    blk = sx2_rule(p, a, b, c, d);
  end

  always_comb begin
    done_nxt = done_r;
    if (retire) begin
      done_nxt = '0;
    end else if (emit) begin
      done_nxt = done_r | pick;
    end
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      blk_r        <= blk;
      col_out_r    <= col_sel;
      row_out_r    <= row_sel;
      run_last_r   <= is_last;
      frame_last_r <= pick[BLK_SELF];
    end
    if (retire) begin
      w_prev_r <= cur;
      w_cur_r  <= q_item.r1_next;
      h2_r     <= h1_r;
      h1_r     <= q_item.pixel;
      if (col_zero) begin
        first_now_r <= q_item.pixel;
      end
      if (q_item.row_end) begin
        r1_first_r <= col_zero ? q_item.pixel : first_now_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_top_left     = blk_r.tl;
  assign out_top_right    = blk_r.tr;
  assign out_bottom_left  = blk_r.bl;
  assign out_bottom_right = blk_r.br;
  assign out_src_col      = col_out_r;
  assign out_src_row      = row_out_r;
  assign out_run_last     = run_last_r;
  assign out_frame_last   = frame_last_r;

endmodule
